/* rtl/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
// No dependencies; every other file imports this package.
package sfr_pkg;

   localparam int BYTE_W             = 8;
   localparam int STR_BYTES          = 8;   // bytes held by a string register
   localparam int STR_W              = BYTE_W * STR_BYTES;
   localparam int LEN_W              = 4;   // length registers and internal lengths
   localparam int CSR_IDX_W          = 2;
   localparam int MAX_TARGET_DEF     = 8;
   localparam int MAX_REPLACEMENT_DEF = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_BYTES       = 2'd0,
      CSR_TARGET_LENGTH      = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   // next-value source for a window cell
   typedef enum logic [1:0] {
      WIN_KEEP,
      WIN_SHIFT,
      WIN_FAR
   } win_sel_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              out_last;
   } sfr_item_type;

endpackage

/* rtl/sfr_ifs.sv */
// Valid/ready channel interfaces: text input, result output and register writes.
// Depends on sfr_pkg.
interface sfr_req_if import sfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              line_end;

   modport source (output valid, output in_byte, output line_end, input ready);
   modport sink   (input valid, input in_byte, input line_end, output ready);
endinterface

interface sfr_rsp_if import sfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_valid;
   logic              out_last;

   modport source (output valid, output out_byte, output byte_valid, output out_last,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                   output ready);
endinterface

interface sfr_csr_if import sfr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [STR_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sfr_win_cell.sv */
// One cell of the pending window: holds a byte and compares it with its target byte.
// Depends on sfr_pkg.
module sfr_win_cell import sfr_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic              is_tail,    // the incoming byte lands here
   input  logic [BYTE_W-1:0] new_byte,
   input  logic [BYTE_W-1:0] shift_byte, // neighbour's view
   input  logic [BYTE_W-1:0] far_byte,
   input  win_sel_type       sel,
   input  logic [BYTE_W-1:0] tgt_byte,
   output logic [BYTE_W-1:0] view,
   output logic              eq_tgt
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   assign view   = is_tail ? new_byte : byte_ff;
   assign eq_tgt = (view == tgt_byte);

   always_comb begin
      case (sel)
         WIN_KEEP:  byte_in = view;
         WIN_SHIFT: byte_in = shift_byte;
         WIN_FAR:   byte_in = far_byte;
         default:   byte_in = view;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         byte_ff <= byte_in;
      end
   end

endmodule

/* rtl/sfr_out_queue.sv */
// Result queue: a row of cells shifting towards the head, loaded with a group per item.
// Depends on sfr_pkg.
module sfr_out_queue import sfr_pkg::*; #(
   parameter int GRP_MAX = 8,
   parameter int DEPTH   = GRP_MAX + 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [LEN_W-1:0] push_len,
   input  sfr_item_type grp [GRP_MAX],
   input  logic         pop_ready,
   output sfr_item_type head,
   output logic         head_valid,
   output logic         room
);

   localparam int QW = $clog2(DEPTH + 1);

   sfr_item_type cells_ff [DEPTH];
   sfr_item_type cells_in [DEPTH];
   sfr_item_type grp_lo   [DEPTH];   // group placed from cell 0
   sfr_item_type grp_hi   [DEPTH];   // group placed from cell 1
   logic [QW-1:0] cnt_ff;
   logic [QW-1:0] cnt_in;
   logic [QW-1:0] base;
   logic          pop;

   for (genvar i = 0; i < DEPTH; i++) begin : g_place
      if (i < GRP_MAX) begin : g_lo
         assign grp_lo[i] = grp[i];
      end else begin : g_lo0
         assign grp_lo[i] = '0;
      end
      if (i == 0) begin : g_hi0
         assign grp_hi[i] = '0;
      end else begin : g_hi
         assign grp_hi[i] = grp[i-1];
      end
   end

   assign head       = cells_ff[0];
   assign head_valid = (cnt_ff != '0);
   assign room       = (cnt_ff <= QW'(1));
   assign pop        = head_valid && pop_ready;
   assign base       = cnt_ff - QW'(pop);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && (i + 1 < DEPTH)) begin
            cells_in[i] = cells_ff[(i + 1) % DEPTH];
         end else begin
            cells_in[i] = cells_ff[i];
         end
         if (push) begin
            if (base == '0) begin
               if (LEN_W'(i) < push_len && i < GRP_MAX) begin
                  cells_in[i] = grp_lo[i];
               end
            end else begin
               if (i >= 1 && LEN_W'(i - 1) < push_len) begin
                  cells_in[i] = grp_hi[i];
               end
            end
         end
      end
      cnt_in = base + (push ? QW'(push_len) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
   end

endmodule

/* rtl/stream_find_replace_top.sv */
// Stream find-and-replace: a line of text in, one byte an item, target matches replaced.
// An accepted item's results are registered in the result queue and leave in order.
// Throughput: one item a cycle while each item yields at most one result and the result
//   port is ready; more results per item hold off input as the queue drains one a cycle.
// Reset (synchronous): empties window and queue, target length 1, other registers 0.
//   No clearing pass; window bytes are only read once written.
module stream_find_replace_top import sfr_pkg::*; #(
   parameter int MAX_TARGET      = MAX_TARGET_DEF,
   parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_chan,
   sfr_rsp_if.source rsp_chan,
   sfr_csr_if.sink   csr_chan
);

   // window cells follow the longest usable target; results per item follow the
   // longer of a full flush and a full replacement
   localparam int WIN_DEPTH = (MAX_TARGET < STR_BYTES) ? MAX_TARGET : STR_BYTES;
   localparam int REP_CAP   = (MAX_REPLACEMENT < STR_BYTES) ? MAX_REPLACEMENT : STR_BYTES;
   localparam int GRP_MAX   = (WIN_DEPTH > REP_CAP) ? WIN_DEPTH : REP_CAP;
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

   // ---------------- configuration registers ----------------
   logic [STR_W-1:0] tgt_bytes_ff;
   logic [LEN_W-1:0] tgt_len_ff;
   logic [STR_W-1:0] rep_bytes_ff;
   logic [LEN_W-1:0] rep_len_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_bytes_ff <= '0;
         tgt_len_ff   <= LEN_W'(1);
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_TARGET_BYTES:       tgt_bytes_ff <= csr_chan.data;
            CSR_TARGET_LENGTH:      tgt_len_ff   <= csr_chan.data[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  rep_bytes_ff <= csr_chan.data;
            CSR_REPLACEMENT_LENGTH: rep_len_ff   <= csr_chan.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // effective lengths: zero target means one, both clipped to the hardware
   logic [LEN_W-1:0] tlen_eff;
   logic [LEN_W-1:0] rlen_eff;

   always_comb begin
      tlen_eff = tgt_len_ff;
      if (tgt_len_ff == '0) begin
         tlen_eff = LEN_W'(1);
      end else if (tgt_len_ff > LEN_W'(WIN_DEPTH)) begin
         tlen_eff = LEN_W'(WIN_DEPTH);
      end
      rlen_eff = (rep_len_ff > LEN_W'(REP_CAP)) ? LEN_W'(REP_CAP) : rep_len_ff;
   end

   // ---------------- pending window: a row of cells ----------------
   logic [CNT_W-1:0]  win_cnt_ff;
   logic [LEN_W-1:0]  cnt_nxt;
   logic [LEN_W-1:0]  shift;
   logic [BYTE_W-1:0] view       [WIN_DEPTH];
   logic [BYTE_W-1:0] nb_byte    [WIN_DEPTH];
   logic [BYTE_W-1:0] far_byte   [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] eq_tgt;
   win_sel_type       win_sel;
   logic              accept;

   assign accept = req_chan.valid && req_chan.ready;

   for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
      if (i < WIN_DEPTH - 1) begin : g_nb
         assign nb_byte[i] = view[i+1];
      end else begin : g_nb_end
         assign nb_byte[i] = view[i];
      end

      sfr_win_cell u_cell (
         .clock      (clock),
         .en         (accept),
         .is_tail    (win_cnt_ff == CNT_W'(i)),
         .new_byte   (req_chan.in_byte),
         .shift_byte (nb_byte[i]),
         .far_byte   (far_byte[i]),
         .sel        (win_sel),
         .tgt_byte   (tgt_bytes_ff[BYTE_W*i +: BYTE_W]),
         .view       (view[i]),
         .eq_tgt     (eq_tgt[i])
      );
   end

   // multi-byte drop of the window, only after the target has been shortened
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         far_byte[i] = view[i];
         for (int j = 0; j < WIN_DEPTH; j++) begin
            if ((i + j < WIN_DEPTH) && (shift == LEN_W'(j))) begin
               far_byte[i] = view[(i + j) % WIN_DEPTH];
            end
         end
      end
   end

   always_comb begin
      case (shift)
         LEN_W'(0): win_sel = WIN_KEEP;
         LEN_W'(1): win_sel = WIN_SHIFT;
         default:   win_sel = WIN_FAR;
      endcase
   end

   // ---------------- per-item decision ----------------
   logic [LEN_W-1:0] c1;        // pending bytes with the new one
   logic             all_match;
   logic             over;
   logic             full;
   logic             hit;
   logic             use_rep;
   logic             bare;
   logic [LEN_W-1:0] gk;        // results this item

   assign c1 = LEN_W'(win_cnt_ff) + LEN_W'(1);

   always_comb begin
      all_match = 1'b1;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         if (LEN_W'(j) < tlen_eff && !eq_tgt[j]) begin
            all_match = 1'b0;
         end
      end
   end

   always_comb begin
      over    = (c1 > tlen_eff);
      full    = (c1 == tlen_eff);
      hit     = full && all_match;
      use_rep = 1'b0;
      bare    = 1'b0;
      gk      = '0;
      shift   = '0;
      cnt_nxt = c1;
      if (req_chan.line_end) begin
         cnt_nxt = '0;
         if (hit) begin
            use_rep = 1'b1;
            if (rlen_eff == '0) begin
               bare = 1'b1;               // deleted match, nothing left: bare end mark
               gk   = LEN_W'(1);
            end else begin
               gk = rlen_eff;
            end
         end else begin
            gk = c1;                      // flush every pending byte
         end
      end else if (over) begin
         gk      = c1 - tlen_eff + LEN_W'(1);
         shift   = gk;
         cnt_nxt = tlen_eff - LEN_W'(1);
      end else if (hit) begin
         use_rep = 1'b1;
         gk      = rlen_eff;
         cnt_nxt = '0;
      end else if (full) begin
         gk      = LEN_W'(1);
         shift   = LEN_W'(1);
         cnt_nxt = tlen_eff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cnt_ff <= '0;
      end else if (accept) begin
         win_cnt_ff <= CNT_W'(cnt_nxt);
      end
   end

   // ---------------- result group ----------------
   sfr_item_type grp [GRP_MAX];

   always_comb begin
      for (int j = 0; j < GRP_MAX; j++) begin
         grp[j].byte_valid = !bare;
         grp[j].out_last   = req_chan.line_end && (LEN_W'(j) == gk - LEN_W'(1));
         if (bare) begin
            grp[j].out_byte = '0;
         end else if (use_rep) begin
            grp[j].out_byte = rep_bytes_ff[BYTE_W*j +: BYTE_W];
         end else if (j < WIN_DEPTH) begin
            grp[j].out_byte = view[j % WIN_DEPTH];
         end else begin
            grp[j].out_byte = '0;
         end
      end
   end

   // ---------------- result queue ----------------
   sfr_item_type head;
   logic         head_valid;
   logic         room;

   sfr_out_queue #(
      .GRP_MAX (GRP_MAX),
      .DEPTH   (GRP_MAX + 1)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && (gk != '0)),
      .push_len   (gk),
      .grp        (grp),
      .pop_ready  (rsp_chan.ready),
      .head       (head),
      .head_valid (head_valid),
      .room       (room)
   );

   // input taken while at most one result is still queued
   assign req_chan.ready      = room;
   assign rsp_chan.valid      = head_valid;
   assign rsp_chan.out_byte   = head.out_byte;
   assign rsp_chan.byte_valid = head.byte_valid;
   assign rsp_chan.out_last   = head.out_last;

endmodule

/* rtl/sfr_checker.sv */
// Port-level checks on the find-and-replace top level, bound to it below.
// Depends on sfr_pkg and stream_find_replace_top.
module sfr_checker import sfr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] out_byte,
   input logic              byte_valid,
   input logic              out_last
);

   // queue and window come out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("not empty and ready after reset");

   // input is only held off while results are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input held off with no result queued");

   // a bare end mark closes a line and carries no byte
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !byte_valid) |-> (out_last && (out_byte == '0)))
      else $error("bare end mark without line end");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(out_byte) && $stable(byte_valid) && $stable(out_last)))
      else $error("stalled result changed");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .out_byte   (rsp_chan.out_byte),
   .byte_valid (rsp_chan.byte_valid),
   .out_last   (rsp_chan.out_last)
);

/* tb/stream_find_replace_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for stream_find_replace_top: directed lines, then random text
// under random target/replacement settings, with random gaps and back-pressure.
// Depends on sfr_pkg, the sfr_*_if interfaces and the block itself.
module stream_find_replace_top_tb;
   import sfr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 240;
   localparam int SETTLE_CYCLES = 4;    // settling wait once every expected result is in
   localparam int PHASE_ITEMS   = 24;

   logic clock = 1'b0;
   logic reset;

   sfr_req_if req_if ();
   sfr_rsp_if rsp_if ();
   sfr_csr_if csr_if ();

   stream_find_replace_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor state: its own copy of the registers and of the pending window.
   // ---------------------------------------------------------------------------
   logic [STR_W-1:0]  cfg_target;
   logic [STR_W-1:0]  cfg_repl;
   logic [LEN_W-1:0]  cfg_target_len;
   logic [LEN_W-1:0]  cfg_repl_len;
   logic [BYTE_W-1:0] window [STR_BYTES];
   int unsigned       window_fill;

   sfr_item_type step_out [$];      // results of the item being predicted
   sfr_item_type results_due [$];   // expected results, oldest first

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned random_items_sent = 0;
   bit          req_gaps_on = 1'b0;
   bit          rsp_stalls_on = 1'b0;

   // Target length as the block uses it: zero counts as one, long values saturate.
   function automatic int unsigned active_target_len();
      if (cfg_target_len == 0) return 1;
      if (cfg_target_len > MAX_TARGET_DEF) return MAX_TARGET_DEF;
      return cfg_target_len;
   endfunction

   function automatic void emit_oldest_byte();
      if (window_fill == 0) return;
      step_out.push_back('{out_byte: window[0], byte_valid: 1'b1, out_last: 1'b0});
      for (int i = 1; i < window_fill; i++) window[i-1] = window[i];
      window_fill--;
   endfunction

   // Works out every result caused by one accepted item and queues them.
   function automatic void predict_replace(input logic [BYTE_W-1:0] text_byte,
                                           input logic is_line_end);
      int unsigned tlen;
      int unsigned rlen;
      bit          hit;
      tlen = active_target_len();
      rlen = (cfg_repl_len > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : cfg_repl_len;
      step_out.delete();
      // at most seven bytes wait between items, so the new one always fits
      window[window_fill] = text_byte;
      window_fill++;
      if (window_fill > tlen) begin
         // target shortened while bytes were pending: drain, no compare this item
         while (window_fill > tlen - 1) emit_oldest_byte();
      end else if (window_fill == tlen) begin
         hit = 1'b1;
         for (int i = 0; i < tlen; i++)
            if (window[i] != cfg_target[BYTE_W*i +: BYTE_W]) hit = 1'b0;
         if (hit) begin
            for (int i = 0; i < rlen; i++)
               step_out.push_back('{out_byte: cfg_repl[BYTE_W*i +: BYTE_W],
                                    byte_valid: 1'b1, out_last: 1'b0});
            window_fill = 0;
         end else begin
            emit_oldest_byte();
         end
      end
      if (is_line_end) begin
         while (window_fill > 0) emit_oldest_byte();
         // nothing left to send: a bare end mark closes the line
         if (step_out.size() == 0)
            step_out.push_back('{out_byte: 8'h00, byte_valid: 1'b0, out_last: 1'b0});
         step_out[step_out.size()-1].out_last = 1'b1;
      end
      foreach (step_out[i]) results_due.push_back(step_out[i]);
   endfunction

   // Mostly no pause, often a short one, now and then a long one.
   function automatic int unsigned pause_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure, and a check of every accepted result.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stalls_on && $urandom_range(0, 99) < 30) begin
            rsp_if.ready <= 1'b0;
            repeat (1 + pause_cycles()) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      sfr_item_type got;
      sfr_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{out_byte: rsp_if.out_byte, byte_valid: rsp_if.byte_valid,
                 out_last: rsp_if.out_last};
         if (results_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, got byte %02h valid %0b last %0b",
                     $time, got.out_byte, got.byte_valid, got.out_last);
         end else begin
            want = results_due.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.out_last !== want.out_last) begin
               mismatch_count++;
               $display({"%0t: result mismatch, expected byte %02h valid %0b last %0b,",
                         " got byte %02h valid %0b last %0b"},
                        $time, want.out_byte, want.byte_valid, want.out_last,
                        got.out_byte, got.byte_valid, got.out_last);
            end
         end
      end
   end

   // Watchdog: a hung handshake or a missing result ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stream_find_replace_top_tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // One text item; valid stays high into the next item unless a gap is drawn.
   task automatic send_byte(input logic [BYTE_W-1:0] text_byte, input logic is_line_end);
      int unsigned gap;
      req_if.valid    <= 1'b1;
      req_if.in_byte  <= text_byte;
      req_if.line_end <= is_line_end;
      do @(posedge clock); while (!req_if.ready);
      predict_replace(text_byte, is_line_end);
      gap = req_gaps_on ? pause_cycles() : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // An unterminated line simply runs on into whatever is sent next.
   task automatic send_line(input logic [BYTE_W-1:0] text [$], input bit terminated);
      foreach (text[i]) send_byte(text[i], terminated && (i == text.size() - 1));
   endtask

   // Block counts as idle once every expected result is in and the settling wait is over,
   // since an item may leave its byte in the window and cause no result at all.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers back to back; only called while idle.
   // Upper bits of the length writes are random, only the low nibble counts.
   task automatic configure(input logic [STR_W-1:0] target_val, input logic [LEN_W-1:0] tlen_val,
                            input logic [STR_W-1:0] repl_val, input logic [LEN_W-1:0] rlen_val);
      logic [STR_W-1:0] data_word;
      csr_index_type    reg_index;
      for (int r = 0; r < 4; r++) begin
         data_word = {$urandom(), $urandom()};
         case (r)
            0: begin reg_index = CSR_TARGET_BYTES;       data_word = target_val; end
            1: begin reg_index = CSR_TARGET_LENGTH;      data_word[LEN_W-1:0] = tlen_val; end
            2: begin reg_index = CSR_REPLACEMENT_BYTES;  data_word = repl_val; end
            default: begin
               reg_index = CSR_REPLACEMENT_LENGTH;
               data_word[LEN_W-1:0] = rlen_val;
            end
         endcase
         csr_if.valid <= 1'b1;
         csr_if.index <= reg_index;
         csr_if.data  <= data_word;
         do @(posedge clock); while (!csr_if.ready);
         case (reg_index)
            CSR_TARGET_BYTES:      cfg_target     = data_word;
            CSR_TARGET_LENGTH:     cfg_target_len = data_word[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES: cfg_repl       = data_word;
            default:               cfg_repl_len   = data_word[LEN_W-1:0];
         endcase
      end
      csr_if.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset settings: one-byte target 00, empty replacement, so every 00 is deleted.
   // The first line ends on a deleted byte with nothing pending: bare end mark.
   task automatic test_reset_defaults();
      send_line('{8'h00, 8'hFF, 8'h00}, 1'b1);
      send_line('{8'h7E}, 1'b1);
   endtask

   // "ab" -> "XYZ", with a false start ahead of the first match and a match on the line end.
   task automatic test_replace_basic();
      wait_idle();
      configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
      send_line('{8'h61, 8'h61, 8'h62, 8'h61, 8'h62}, 1'b1);
   endtask

   // Longest target and replacement (written as 15, saturating to eight), so one item
   // yields eight results; then length zero, read as a one-byte target.
   task automatic test_length_extremes();
      wait_idle();
      configure({STR_W{1'b1}}, 4'd15, 64'h0807060504030201, 4'd15);
      send_line('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
      wait_idle();
      configure(64'h00000000000000FF, 4'd0, {STR_W{1'b0}}, 4'd0);
      send_line('{8'hFF}, 1'b1);
   endtask

   // Three bytes left pending under a four-byte target, then the target cut to two:
   // the next item drains the window without a compare, though its last two bytes
   // would match; the line then ends on a miss.
   task automatic test_target_shortened();
      wait_idle();
      configure(64'h64636261, 4'd4, 64'h5A, 4'd1);
      send_line('{8'h61, 8'h62, 8'h63}, 1'b0);
      wait_idle();
      configure(64'h7163, 4'd2, 64'h5A, 4'd1);
      send_line('{8'h71, 8'h7A}, 1'b1);
   endtask

   // Random phases: fresh settings each phase, text built mostly from copies and
   // fragments of the target so that matches and near-misses are common.
   task automatic test_random_text();
      logic [BYTE_W-1:0] line [$];
      logic [STR_W-1:0]  target_val;
      logic [LEN_W-1:0]  tlen_val;
      logic [LEN_W-1:0]  rlen_val;
      int unsigned       tlen;
      int unsigned       line_len;
      int unsigned       piece;
      int unsigned       phase_items;
      int unsigned       roll;
      int unsigned       mode;
      while (random_items_sent < RANDOM_ITEMS) begin
         wait_idle();
         roll = $urandom_range(0, 9);
         case (roll)
            0:       tlen_val = 4'd0;
            1:       tlen_val = LEN_W'($urandom_range(9, 15));
            2:       tlen_val = 4'd1;
            3:       tlen_val = 4'd8;
            default: tlen_val = LEN_W'($urandom_range(1, 8));
         endcase
         roll = $urandom_range(0, 9);
         case (roll)
            0:       rlen_val = 4'd0;
            1:       rlen_val = LEN_W'($urandom_range(9, 15));
            2:       rlen_val = 4'd8;
            default: rlen_val = LEN_W'($urandom_range(0, 8));
         endcase
         roll = $urandom_range(0, 9);
         if (roll == 0) target_val = '0;
         else if (roll == 1) target_val = '1;
         else if (roll < 6) begin
            // two-letter alphabet: plenty of partial matches
            for (int i = 0; i < STR_BYTES; i++)
               target_val[BYTE_W*i +: BYTE_W] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
         end else target_val = {$urandom(), $urandom()};
         configure(target_val, tlen_val, {$urandom(), $urandom()}, rlen_val);

         // idle pattern for this phase, including phases with none at all
         mode = $urandom_range(0, 3);
         req_gaps_on   = mode[0];
         rsp_stalls_on = mode[1];

         tlen = active_target_len();
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && random_items_sent < RANDOM_ITEMS) begin
            line.delete();
            line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                   : $urandom_range(1, 12);
            while (line.size() < line_len) begin
               roll = $urandom_range(0, 99);
               if (roll < 35) begin
                  for (int i = 0; i < tlen; i++) line.push_back(target_val[BYTE_W*i +: BYTE_W]);
               end else if (roll < 55) begin
                  piece = $urandom_range(1, tlen);
                  for (int i = 0; i < piece; i++) line.push_back(target_val[BYTE_W*i +: BYTE_W]);
               end else if (roll < 85) begin
                  piece = $urandom_range(0, tlen - 1);
                  line.push_back(target_val[BYTE_W*piece +: BYTE_W]);
               end else begin
                  line.push_back(BYTE_W'($urandom_range(0, 255)));
               end
            end
            // an unterminated line at the end of a phase sees its settings change mid-line
            send_line(line, $urandom_range(0, 7) != 0);
            phase_items       += line.size();
            random_items_sent += line.size();
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.in_byte  <= '0;
      req_if.line_end <= 1'b0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= CSR_TARGET_BYTES;
      csr_if.data     <= '0;
      // predictor mirrors the reset state of the block
      cfg_target     = '0;
      cfg_target_len = 4'd1;
      cfg_repl       = '0;
      cfg_repl_len   = 4'd0;
      window_fill    = 0;
      for (int i = 0; i < STR_BYTES; i++) window[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      test_reset_defaults();
      test_replace_basic();
      test_length_extremes();
      test_target_shortened();
      test_random_text();

      // drain, then a short watch for stray results
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("stream_find_replace_top_tb OK");
      end else begin
         $display("stream_find_replace_top_tb NOT OK");
      end
      $finish;
   end

endmodule
